// ===== rtl/core/calendar_date_string_validator_macros.svh =====
// Assertion macros shared by the date validator checker.
`ifndef CALENDAR_DATE_STRING_VALIDATOR_MACROS_SVH
`define CALENDAR_DATE_STRING_VALIDATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CDSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CDSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cdsv_pkg.sv =====
// Types, codes and month tables for the calendar date string validator.
package cdsv_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DAY_W   = 7;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [POS_W-1:0]  LAST_POS       = 4'd10;
  localparam logic [POS_W-1:0]  POS_SAT        = 4'd12;
  localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = 14'd9999;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MAX = 2'd1;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_LENGTH,
    ERR_SEPARATOR,
    ERR_DAY,
    ERR_YEAR,
    ERR_MON_LETTERS,
    ERR_MON_NAME,
    ERR_DAY_MONTH
  } err_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_word_t;

  typedef struct packed {
    logic              date_ok;
    logic [2:0]        error_kind;
    logic [DAY_W-1:0]  day_value;
    logic [MON_W-1:0]  month_number;
    logic [YEAR_W-1:0] year_value;
  } verdict_word_t;

  // Everything the verdict logic needs about one finished string.
  typedef struct packed {
    logic              length_ok;
    logic              sep_ok;
    logic              day_ok;
    logic              year_ok;
    logic              mon_ok;
    logic [DAY_W-1:0]  day;
    logic [23:0]       letters;
    logic [YEAR_W-1:0] year;
    logic [6:0]        year_hi;
    logic [6:0]        year_lo;
  } date_summary_t;

  // Lower-case Portuguese month abbreviations, index 0 is January.
  function automatic logic [23:0] month_code(input logic [3:0] idx);
    logic [23:0] code;
    case (idx)
      4'd0:    code = 24'h6A616E;
      4'd1:    code = 24'h666576;
      4'd2:    code = 24'h6D6172;
      4'd3:    code = 24'h616272;
      4'd4:    code = 24'h6D6169;
      4'd5:    code = 24'h6A756E;
      4'd6:    code = 24'h6A756C;
      4'd7:    code = 24'h61676F;
      4'd8:    code = 24'h736574;
      4'd9:    code = 24'h6F7574;
      4'd10:   code = 24'h6E6F76;
      4'd11:   code = 24'h64657A;
      default: code = 24'h000000;
    endcase
    return code;
  endfunction

  // Longest day of a month numbered 1..12; February allows the leap day.
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon);
    logic [DAY_W-1:0] days;
    case (mon)
      4'd2:    days = 7'd29;
      4'd4:    days = 7'd30;
      4'd6:    days = 7'd30;
      4'd9:    days = 7'd30;
      4'd11:   days = 7'd30;
      default: days = 7'd31;
    endcase
    return days;
  endfunction

endpackage

// ===== rtl/core/cdsv_parse.sv =====
// Input register and per-character parser that builds a summary of each string.
module cdsv_parse
  import cdsv_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_stall,
  input  char_word_t    char_word,
  output logic          sum_valid,
  input  logic          sum_take,
  output date_summary_t sum_word
);

  logic                in_vld;
  char_word_t          in_word;
  logic                fire;

  logic [POS_W-1:0]    pos;
  logic [DAY_W-1:0]    day_acc;
  logic [23:0]         letters;
  logic [YEAR_W-1:0]   year_acc;
  logic [6:0]          year_hi;
  logic [6:0]          year_lo;
  logic                sep_ok, day_ok, year_ok, mon_ok;

  logic [POS_W-1:0]    pos_next;
  logic [DAY_W-1:0]    day_acc_next;
  logic [23:0]         letters_next;
  logic [YEAR_W-1:0]   year_acc_next;
  logic [6:0]          year_hi_next;
  logic [6:0]          year_lo_next;
  logic                sep_ok_next, day_ok_next, year_ok_next, mon_ok_next;

  logic [7:0]          c;
  logic [7:0]          lc;
  logic                is_dig;
  logic [3:0]          dig;
  logic                sum_room;

  // A non-last character only touches the parser state; a last one also
  // needs room in the summary register.
  assign sum_room   = !sum_valid || sum_take;
  assign fire       = in_vld && (!in_word.is_last || sum_room);
  assign char_stall = in_vld && !fire;

  assign c      = in_word.char_code;
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign dig    = is_dig ? c[3:0] : 4'd0;
  assign lc     = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;

  always_comb begin
    pos_next      = (pos < POS_SAT) ? (pos + 4'd1) : POS_SAT;
    day_acc_next  = day_acc;
    letters_next  = letters;
    year_acc_next = year_acc;
    year_hi_next  = year_hi;
    year_lo_next  = year_lo;
    sep_ok_next   = sep_ok;
    day_ok_next   = day_ok;
    year_ok_next  = year_ok;
    mon_ok_next   = mon_ok;
    case (pos)
      4'd0, 4'd1: begin
        day_acc_next = {day_acc[3:0], 3'b000} + {day_acc[5:0], 1'b0} + {3'b000, dig};
        if (!is_dig) day_ok_next = 1'b0;
      end
      4'd2, 4'd6: begin
        if (c != 8'h2F) sep_ok_next = 1'b0;
      end
      4'd3, 4'd4, 4'd5: begin
        letters_next = {letters[15:0], lc};
        if (!((lc >= 8'h61) && (lc <= 8'h7A))) mon_ok_next = 1'b0;
      end
      4'd7, 4'd8: begin
        year_acc_next = {year_acc[10:0], 3'b000} + {year_acc[12:0], 1'b0}
                        + {10'd0, dig};
        year_hi_next  = {year_hi[3:0], 3'b000} + {year_hi[5:0], 1'b0} + {3'b000, dig};
        if (!is_dig) year_ok_next = 1'b0;
      end
      4'd9, 4'd10: begin
        year_acc_next = {year_acc[10:0], 3'b000} + {year_acc[12:0], 1'b0}
                        + {10'd0, dig};
        year_lo_next  = {year_lo[3:0], 3'b000} + {year_lo[5:0], 1'b0} + {3'b000, dig};
        if (!is_dig) year_ok_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_vld || fire) begin
      in_vld <= char_valid;
    end
    if (!in_vld || fire) begin
      in_word <= char_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_word.is_last)) begin
      pos      <= '0;
      day_acc  <= '0;
      letters  <= '0;
      year_acc <= '0;
      year_hi  <= '0;
      year_lo  <= '0;
      sep_ok   <= 1'b1;
      day_ok   <= 1'b1;
      year_ok  <= 1'b1;
      mon_ok   <= 1'b1;
    end else if (fire) begin
      pos      <= pos_next;
      day_acc  <= day_acc_next;
      letters  <= letters_next;
      year_acc <= year_acc_next;
      year_hi  <= year_hi_next;
      year_lo  <= year_lo_next;
      sep_ok   <= sep_ok_next;
      day_ok   <= day_ok_next;
      year_ok  <= year_ok_next;
      mon_ok   <= mon_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_room) begin
      sum_valid <= fire && in_word.is_last;
    end
    if (fire && in_word.is_last) begin
      sum_word.length_ok <= (pos == LAST_POS);
      sum_word.sep_ok    <= sep_ok_next;
      sum_word.day_ok    <= day_ok_next;
      sum_word.year_ok   <= year_ok_next;
      sum_word.mon_ok    <= mon_ok_next;
      sum_word.day       <= day_acc_next;
      sum_word.letters   <= letters_next;
      sum_word.year      <= year_acc_next;
      sum_word.year_hi   <= year_hi_next;
      sum_word.year_lo   <= year_lo_next;
    end
  end

endmodule

// ===== rtl/core/cdsv_judge.sv =====
// Verdict logic: month lookup, ordered checks and the result register.
module cdsv_judge
  import cdsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              sum_valid,
  output logic              sum_take,
  input  date_summary_t     sum_word,
  input  logic [YEAR_W-1:0] year_min,
  input  logic [YEAR_W-1:0] year_max,
  output logic              verdict_valid,
  input  logic              verdict_stall,
  output verdict_word_t     verdict_word
);

  logic [MON_W-1:0] mon;
  logic             leap;
  err_kind_t        err;

  assign sum_take = !verdict_valid || !verdict_stall;

  always_comb begin
    mon = '0;
    for (int i = 0; i < 12; i++) begin
      if ((mon == '0) && (sum_word.letters == month_code(4'(i)))) begin
        mon = 4'(i + 1);
      end
    end
  end

  // The year is hi * 100 + lo; since 100 is a multiple of four, the
  // Gregorian rule reduces to the low bits of the two digit pairs.
  assign leap = (sum_word.year_lo == 7'd0) ? (sum_word.year_hi[1:0] == 2'b00)
                                           : (sum_word.year_lo[1:0] == 2'b00);

  always_comb begin
    if (!sum_word.length_ok) begin
      err = ERR_LENGTH;
    end else if (!sum_word.sep_ok) begin
      err = ERR_SEPARATOR;
    end else if (!sum_word.day_ok || (sum_word.day < 7'd1) || (sum_word.day > 7'd31)) begin
      err = ERR_DAY;
    end else if (!sum_word.year_ok || (sum_word.year < year_min)
                 || (sum_word.year > year_max)) begin
      err = ERR_YEAR;
    end else if (!sum_word.mon_ok) begin
      err = ERR_MON_LETTERS;
    end else if (mon == '0) begin
      err = ERR_MON_NAME;
    end else if (sum_word.day > month_days(mon)) begin
      err = ERR_DAY_MONTH;
    end else if ((mon == 4'd2) && (sum_word.day > 7'd28) && !leap) begin
      err = ERR_DAY_MONTH;
    end else begin
      err = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (sum_take) begin
      verdict_valid <= sum_valid;
    end
    if (sum_take && sum_valid) begin
      verdict_word.date_ok      <= (err == ERR_NONE);
      verdict_word.error_kind   <= err;
      verdict_word.day_value    <= sum_word.day;
      verdict_word.month_number <= mon;
      verdict_word.year_value   <= sum_word.year;
    end
  end

endmodule

// ===== rtl/core/calendar_date_string_validator.sv =====
// Top level of the dd/mmm/yyyy date string validator.
//
//   Channel   Signals                          Direction  Word
//   char      char_valid char_stall char_word  in         char_word_t
//   verdict   verdict_valid verdict_stall      out        verdict_word_t
//   cfg       cfg_valid cfg_ready cfg_index    in         year_min / year_max
//
// One character word is taken every clock cycle as long as the output side
// keeps up. The verdict for a string is carried from its last character
// through the input register, the summary register and the verdict register.
// Reset is synchronous and active high; it clears the parser state and sets
// year_min to 0 and year_max to 9999. A stall on the verdict channel first
// fills the summary register; only a last character then stalls the input.
module calendar_date_string_validator
  import cdsv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  char_word_t           char_word,
  output logic                 verdict_valid,
  input  logic                 verdict_stall,
  output verdict_word_t        verdict_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [YEAR_W-1:0]    cfg_data
);

  logic              sum_valid;
  logic              sum_take;
  date_summary_t     sum_word;
  logic [YEAR_W-1:0] year_min;
  logic [YEAR_W-1:0] year_max;

  // Register writes complete in the cycle they are offered; indexes beyond
  // the two year limits are accepted and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_min <= '0;
      year_max <= YEAR_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_YEAR_MIN) year_min <= cfg_data;
      if (cfg_index == CFG_YEAR_MAX) year_max <= cfg_data;
    end
  end

  // Character parser: input register, running accumulators, summary register.
  cdsv_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .sum_valid  (sum_valid),
    .sum_take   (sum_take),
    .sum_word   (sum_word)
  );

  // Ordered checks on the summary, into the verdict output register.
  cdsv_judge u_judge (
    .clk           (clk),
    .rst           (rst),
    .sum_valid     (sum_valid),
    .sum_take      (sum_take),
    .sum_word      (sum_word),
    .year_min      (year_min),
    .year_max      (year_max),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_word  (verdict_word)
  );

endmodule

// ===== rtl/core/cdsv_checker.sv =====
// Port-level checker for the date validator and its bind to the top level.
`include "calendar_date_string_validator_macros.svh"

module cdsv_checker
  import cdsv_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          verdict_valid,
  input logic          verdict_stall,
  input verdict_word_t verdict_word
);

  `CDSV_ASSERT_NEXT(a_hold, verdict_valid && verdict_stall, verdict_valid && $stable(verdict_word), "stalled verdict changed")
  `CDSV_ASSERT_NOW(a_ok_code, verdict_valid, verdict_word.date_ok == (verdict_word.error_kind == ERR_NONE), "date_ok disagrees with error_kind")
  `CDSV_ASSERT_NOW(a_ok_fields, verdict_valid && verdict_word.date_ok, (verdict_word.month_number != 4'd0) && (verdict_word.day_value != 7'd0) && (verdict_word.day_value <= 7'd31), "valid date with bad fields")
  `CDSV_ASSERT_NOW(a_month_range, verdict_valid && (verdict_word.error_kind == ERR_DAY_MONTH), (verdict_word.month_number != 4'd0) && (verdict_word.month_number <= 4'd12), "month check without a month")

endmodule

bind calendar_date_string_validator cdsv_checker u_cdsv_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the dd/mmm/yyyy date string validator.
module tb
  import cdsv_pkg::*;
();

  typedef logic [7:0] char_q_t[$];

  // Receiver stall patterns on the verdict channel.
  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTS,
    STALL_HEAVY
  } stall_mode_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_CHARS  = 600;
  localparam int STRING_LEN    = 11;
  localparam int POS_CAP       = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Bit positions inside the format flags of the string being parsed.
  localparam int FMT_SEP  = 0;
  localparam int FMT_DAY  = 1;
  localparam int FMT_YEAR = 2;
  localparam int FMT_MON  = 3;

  localparam logic [7:0] SLASH = 8'h2F;

  // Lower-case month abbreviations, January first, and the month lengths
  // with the leap day allowed in February.
  localparam logic [23:0] MONTH_NAMES [12] = '{
    24'h6A616E, 24'h666576, 24'h6D6172, 24'h616272, 24'h6D6169, 24'h6A756E,
    24'h6A756C, 24'h61676F, 24'h736574, 24'h6F7574, 24'h6E6F76, 24'h64657A
  };
  localparam int MONTH_LEN [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int CENTURIES [7]  = '{1600, 1700, 1800, 1900, 2000, 2100, 2400};

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 char_valid    = 1'b0;
  logic                 char_stall;
  char_word_t           char_word     = '0;
  logic                 verdict_valid;
  logic                 verdict_stall = 1'b0;
  verdict_word_t        verdict_word;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [YEAR_W-1:0]    cfg_data      = '0;

  calendar_date_string_validator DUT (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_word     (char_word),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_word  (verdict_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mirror of the parser state and of the year window. It is advanced on
  // every accepted character word and produces the verdict that a last
  // character must lead to.
  logic [3:0]        str_pos   = '0;
  logic [DAY_W-1:0]  day_acc   = '0;
  logic [23:0]       mon_chars = '0;
  logic [YEAR_W-1:0] year_acc  = '0;
  logic [3:0]        fmt_ok    = 4'hF;
  logic [YEAR_W-1:0] year_lo   = '0;
  logic [YEAR_W-1:0] year_hi   = YEAR_MAX_RESET;

  verdict_word_t verdicts_due[$];
  verdict_word_t want_verdict;
  int            mismatch_count = 0;
  int            cycle_count    = 0;

  // Sender and receiver pacing, changed from phase to phase.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_cnt  = 0;
  int          gap_max    = 0;
  int          burst_left = 0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Gregorian rule: every fourth year, but only every fourth century.
  function automatic bit is_leap(input int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 == 0 && y % 400 != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_string();
    str_pos   = '0;
    day_acc   = '0;
    mon_chars = '0;
    year_acc  = '0;
    fmt_ok    = 4'hF;
  endfunction

  function automatic void track_char(input char_word_t w);
    logic [3:0]    p;
    logic [7:0]    c;
    logic [7:0]    lc;
    int            digit;
    int            mon;
    int            day;
    int            year;
    err_kind_t     err;
    verdict_word_t v;
    p = str_pos;
    c = w.char_code;
    digit = is_digit(c) ? int'(c) - 'h30 : 0;
    if (p <= 4'd1) begin
      if (!is_digit(c)) fmt_ok[FMT_DAY] = 1'b0;
      day_acc = DAY_W'(int'(day_acc) * 10 + digit);
    end else if (p == 4'd2 || p == 4'd6) begin
      if (c != SLASH) fmt_ok[FMT_SEP] = 1'b0;
    end else if (p >= 4'd3 && p <= 4'd5) begin
      lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
      if (!(lc >= 8'h61 && lc <= 8'h7A)) fmt_ok[FMT_MON] = 1'b0;
      mon_chars = {mon_chars[15:0], lc};
    end else if (p >= 4'd7 && p <= 4'd10) begin
      if (!is_digit(c)) fmt_ok[FMT_YEAR] = 1'b0;
      year_acc = YEAR_W'(int'(year_acc) * 10 + digit);
    end
    str_pos = (int'(p) < POS_CAP) ? p + 4'd1 : 4'(POS_CAP);
    if (!w.is_last) return;

    mon = 0;
    for (int i = 0; i < 12; i++) begin
      if (mon == 0 && mon_chars == MONTH_NAMES[i]) mon = i + 1;
    end
    day  = int'(day_acc);
    year = int'(year_acc);

    // The first failing check in this order gives the error kind.
    if (int'(p) + 1 != STRING_LEN) err = ERR_LENGTH;
    else if (!fmt_ok[FMT_SEP]) err = ERR_SEPARATOR;
    else if (!fmt_ok[FMT_DAY] || day < 1 || day > 31) err = ERR_DAY;
    else if (!fmt_ok[FMT_YEAR] || year < int'(year_lo) || year > int'(year_hi)) err = ERR_YEAR;
    else if (!fmt_ok[FMT_MON]) err = ERR_MON_LETTERS;
    else if (mon == 0) err = ERR_MON_NAME;
    else if (day > MONTH_LEN[mon-1]) err = ERR_DAY_MONTH;
    else if (mon == 2 && day > 28 && !is_leap(year)) err = ERR_DAY_MONTH;
    else err = ERR_NONE;

    v.date_ok      = (err == ERR_NONE);
    v.error_kind   = err;
    v.day_value    = day_acc;
    v.month_number = MON_W'(mon);
    v.year_value   = year_acc;
    verdicts_due.push_back(v);
    clear_string();
  endfunction

  // Sends one character word. The sender works in bursts; at the start of
  // each burst it may drop valid for a random gap. The word is
  // accepted at the first edge that sees it without a stall.
  task automatic send_char(input logic [7:0] c, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_valid <= 1'b1;
    char_word  <= '{char_code: c, is_last: last};
    do @(posedge clk); while (char_stall);
    track_char(char_word);
  endtask

  task automatic send_bytes(input char_q_t text);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_text(input string s);
    char_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_bytes(text);
  endtask

  // Drops valid, lets every pending verdict come out and then lets the
  // pipeline drain before anything is reconfigured.
  task automatic wait_idle();
    char_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; valid stays high when another write follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= YEAR_W'(data);
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    if (idx == CFG_YEAR_MIN) year_lo = YEAR_W'(data);
    else if (idx == CFG_YEAR_MAX) year_hi = YEAR_W'(data);
  endtask

  task automatic set_years(input int lo, input int hi);
    write_reg(CFG_YEAR_MIN, lo, 1'b1);
    write_reg(CFG_YEAR_MAX, hi, 1'b0);
  endtask

  function automatic void put_digits(ref char_q_t text, input int val, input int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    for (int k = 0; k < n; k++) begin
      text.push_back(8'(8'h30 + (val / div) % 10));
      div /= 10;
    end
  endfunction

  // Builds one random string. Most are well-formed dates with random
  // content aimed at the month lengths, leap days and the year window; the
  // rest are dates with one corrupted character, dates of the wrong length
  // and plain noise.
  function automatic void make_date_text(output char_q_t text);
    int mon;
    int day;
    int year;
    int lo;
    int hi;
    int kind;
    logic [7:0] letter;
    text = {};
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 16)) text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    mon = $urandom_range(0, 11);
    if (mon == 1 && $urandom_range(0, 1) == 1) day = $urandom_range(28, 29);
    else if ($urandom_range(0, 4) != 0) day = $urandom_range(1, MONTH_LEN[mon]);
    else day = $urandom_range(0, 39);
    lo = int'(year_lo) - 2;
    hi = ((year_hi > year_lo) ? int'(year_hi) : int'(year_lo)) + 2;
    if (lo < 0) lo = 0;
    if (hi > 9999) hi = 9999;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: year = $urandom_range(lo, hi);
      4, 5:       year = CENTURIES[$urandom_range(0, 6)];
      6:          year = $urandom_range(0, 2499) * 4;
      default:    year = $urandom_range(0, 9999);
    endcase
    put_digits(text, day, 2);
    text.push_back(SLASH);
    for (int k = 2; k >= 0; k--) begin
      letter = MONTH_NAMES[mon][8*k +: 8];
      if ($urandom_range(0, 2) == 0) letter -= 8'h20;
      text.push_back(letter);
    end
    text.push_back(SLASH);
    put_digits(text, year, 4);
    if (kind < 25) begin
      text[$urandom_range(0, 10)] = 8'($urandom_range(0, 255));
    end else if (kind < 30) begin
      if ($urandom_range(0, 1) == 0) begin
        void'(text.pop_back());
      end else begin
        repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Verdict stall pattern, one of quiet, random, long bursts or heavy.
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_mode)
      STALL_NONE:   verdict_stall <= 1'b0;
      STALL_RANDOM: verdict_stall <= ($urandom_range(0, 99) < 40);
      STALL_BURSTS: verdict_stall <= ((stall_cnt % 23) < 11);
      default:      verdict_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  function automatic void compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Each accepted verdict word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && verdict_valid && !verdict_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict word with none expected, actual %p", $time, verdict_word);
        mismatch_count++;
      end else begin
        want_verdict = verdicts_due.pop_front();
        compare_field("date_ok", want_verdict.date_ok, verdict_word.date_ok);
        compare_field("error_kind", want_verdict.error_kind, verdict_word.error_kind);
        compare_field("day_value", want_verdict.day_value, verdict_word.day_value);
        compare_field("month_number", want_verdict.month_number, verdict_word.month_number);
        compare_field("year_value", want_verdict.year_value, verdict_word.year_value);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts pending", $time, verdicts_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Dates at the calendar edges under the reset year window, valid and not,
  // including leap days in leap and non-leap centuries and mixed case.
  task automatic test_calendar_edges();
    send_text("01/jan/0000");
    send_text("31/dez/9999");
    send_text("29/fev/2000");
    send_text("29/fev/1900");
    send_text("29/fev/2024");
    send_text("29/fev/2023");
    send_text("31/abr/2021");
    send_text("30/SET/1999");
    send_text("15/AgO/1969");
  endtask

  // One string for each way the format can fail, plus the extreme byte
  // values and a string long enough to saturate the position count.
  task automatic test_format_errors();
    char_q_t text;
    send_text("7");
    send_text("1/jan/2000");
    send_text("01/jan/20000");
    send_text("01/jan/2000/01/jan/2000");
    send_text("01-jan/2000");
    send_text("01/jan-2000");
    send_text("00/jan/2000");
    send_text("32/abc/2000");
    send_text("a1/jan/2000");
    send_text("10/jan/20x0");
    send_text("10/j1n/2000");
    send_text("10/[an/2000");
    send_text("10/abc/2000");
    text = {8'h00, 8'hFF, SLASH, 8'h6A, 8'h61, 8'h6E, SLASH, 8'h32, 8'h30, 8'h30, 8'hFF};
    send_bytes(text);
  endtask

  // Year window boundaries, an empty window, a one-year window and a write to the unused index.
  task automatic test_year_window();
    wait_idle();
    set_years(1900, 2100);
    send_text("01/mar/1899");
    send_text("01/mar/1900");
    send_text("01/mar/2100");
    send_text("01/mar/2101");
    wait_idle();
    set_years(6000, 2200);
    send_text("01/mar/3000");
    wait_idle();
    set_years(9999, 9999);
    send_text("01/out/9999");
    send_text("01/nov/9998");
    wait_idle();
    write_reg(CFG_UNUSED, 1234, 1'b0);
    send_text("28/fev/9999");
    wait_idle();
    set_years(0, 9999);
  endtask

  // Random strings in phases. Each phase picks a year window, a sender gap
  // limit and a receiver stall pattern, then runs a handful of strings.
  task automatic test_random_strings();
    char_q_t text;
    int chars_sent;
    int strings_left;
    int lo;
    int hi;
    chars_sent   = 0;
    strings_left = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (strings_left == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: begin
            lo = 0;
            hi = 9999;
          end
          1: begin
            lo = $urandom_range(0, 9999);
            hi = $urandom_range(lo, 9999);
          end
          2: begin
            lo = $urandom_range(1, 9999);
            hi = $urandom_range(0, lo - 1);
          end
          default: begin
            lo = $urandom_range(0, 9999);
            hi = lo;
          end
        endcase
        set_years(lo, hi);
        stall_mode   = stall_mode_t'($urandom_range(0, 3));
        gap_max      = $urandom_range(0, 2) * 4;
        strings_left = $urandom_range(6, 14);
      end
      make_date_text(text);
      send_bytes(text);
      chars_sent += text.size();
      strings_left--;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_calendar_edges();
    stall_mode = STALL_RANDOM;
    gap_max    = 4;
    test_format_errors();
    test_year_window();
    test_random_strings();
    wait_idle();
    if (mismatch_count == 0 && verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
